// ----- hw/rtl/uplink_frame_crc_repeat_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the uplink frame CRC and repeat encoder
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef UPLINK_FRAME_CRC_REPEAT_ENCODER_MACROS_SVH
`define UPLINK_FRAME_CRC_REPEAT_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define UFCRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define UFCRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define UFCRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UFCRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/ufcre_pkg.sv -----
// ----------------------------------------------------------------------------
// ufcre_pkg
// Types, constants and bit-step functions of the uplink CRC repeat encoder.
// ----------------------------------------------------------------------------
package ufcre_pkg;

	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [15:0] CRC_INVERT   = 16'hffff;
	localparam logic [15:0] SLICE_MASK   = 16'h00c0;
	localparam logic [15:0] LOOKUP_MODE1 = 16'h0a00;
	localparam logic [15:0] LOOKUP_MODE2 = 16'h1100;

	localparam logic [1:0] MODE_COPY  = 2'd0;
	localparam logic [1:0] MODE_LUT_A = 2'd1;
	localparam logic [1:0] MODE_LUT_B = 2'd2;

	// which byte of an item goes out next
	typedef enum logic [1:0] {
		PH_DATA,
		PH_CRC_HI,
		PH_CRC_LO
	} ufcre_phase_t;

	typedef struct packed {
		logic adv;   // take one byte step
		logic clr;   // wipe state after this step
	} ufcre_step_t;

	typedef struct packed {
		logic [15:0] shift;
		logic [15:0] accum;
		logic [7:0]  coded;
	} ufcre_enc_res_t;

	function automatic logic [15:0] lookup_word(input logic [1:0] mode);
		logic [15:0] w;
		unique case (mode)
			MODE_LUT_A: w = LOOKUP_MODE1;
			MODE_LUT_B: w = LOOKUP_MODE2;
			default:    w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic ufcre_enc_res_t enc_byte(input logic [15:0] shift,
			input logic [15:0] accum, input logic [15:0] lut, input logic [7:0] b);
		logic [15:0]    s;
		logic [15:0]    a;
		logic [2:0]     sel;
		ufcre_enc_res_t r;
		s = shift | {8'h00, b};
		a = accum;
		for (int k = 0; k < 8; k++) begin
			sel = {s[9:8], 1'b0};
			a = a ^ ((lut >> sel) & SLICE_MASK);
			s = {s[14:0], 1'b0};
			a = {a[14:0], 1'b0};
		end
		r.shift = s;
		r.accum = a;
		r.coded = a[15:8] ^ s[15:8];
		return r;
	endfunction

endpackage

// ----- hw/rtl/ufcre_crc.sv -----
// ----------------------------------------------------------------------------
// ufcre_crc
// Running CRC-16 (0x1021, zero seed, MSB first), one byte per step.
// ----------------------------------------------------------------------------
module ufcre_crc
	import ufcre_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ufcre_step_t step,
	input  logic [7:0]  data,
	output logic [15:0] crc
);

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (step.clr) begin
			crc_q <= '0;
		end else if (step.adv) begin
			crc_q <= crc_byte(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

// ----- hw/rtl/ufcre_enc.sv -----
// ----------------------------------------------------------------------------
// ufcre_enc
// Repeat encoder: shift register and accumulator, eight bit steps per byte.
// ----------------------------------------------------------------------------
module ufcre_enc
	import ufcre_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ufcre_step_t step,
	input  logic [1:0]  mode,
	input  logic [7:0]  data,
	output logic [7:0]  coded
);

	logic [15:0]    shift_q;
	logic [15:0]    accum_q;
	ufcre_enc_res_t res;

	assign res   = enc_byte(shift_q, accum_q, lookup_word(mode), data);
	assign coded = res.coded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			accum_q <= '0;
		end else if (step.clr) begin
			shift_q <= '0;
			accum_q <= '0;
		end else if (step.adv) begin
			shift_q <= res.shift;
			accum_q <= res.accum;
		end
	end

endmodule

// ----- hw/rtl/uplink_frame_crc_repeat_encoder.sv -----
// ----------------------------------------------------------------------------
// uplink_frame_crc_repeat_encoder
// Byte-wide frame CRC-16 and repeat encoder with appended, encoded FCS.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries data_byte and frame_end; output
// channel out_valid/out_ready carries coded_byte, is_crc and last_out.
// The user must write the repeat mode via cfg_wr_en/cfg_wr_data only while
// the block idles; the block does not enforce this. An accepted byte is held
// and encoded in the input register, then lands in the output register once
// that is free or being drained. Ordinary bytes stream at one per cycle when
// not stalled. A byte with frame_end stays in the input register for three
// output bytes: the data byte, then the inverted CRC high and low bytes, each
// run through the same encoder; the byte state machine sets this. The CRC and
// encoder state then clear. A stalled receiver holds the output register; the
// input register keeps one byte and in_ready drops until the output frees up.
// Reset clears the CRC, the encoder state, the mode and both valid flags.
// ----------------------------------------------------------------------------
`include "uplink_frame_crc_repeat_encoder_macros.svh"

module uplink_frame_crc_repeat_encoder
	import ufcre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] coded_byte,
	output logic       is_crc,
	output logic       last_out,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data
);

	logic [1:0]   mode_q;
	logic         valid_s1;
	logic [7:0]   data_byte_s1;
	logic         frame_end_s1;
	ufcre_phase_t phase_q, phase_d;
	logic         fire;
	logic         consume;
	logic [15:0]  crc;
	logic [15:0]  fcs;
	logic [7:0]   enc_in;
	logic [7:0]   coded;
	ufcre_step_t  crc_step;
	ufcre_step_t  enc_step;
	logic         out_valid_q;
	logic [7:0]   coded_byte_q;
	logic         is_crc_q;
	logic         last_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COPY;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// a result moves when the output register is free or being drained
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1 <= data_byte;
			frame_end_s1 <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
		end else begin
			phase_q <= phase_d;
		end
	end

	assign fcs = crc ^ CRC_INVERT;

	always_comb begin
		phase_d      = phase_q;
		consume      = 1'b0;
		crc_step.adv = 1'b0;
		crc_step.clr = 1'b0;
		enc_step.adv = fire;
		enc_step.clr = 1'b0;
		enc_in       = data_byte_s1;
		unique case (phase_q)
			PH_DATA: begin
				crc_step.adv = fire;
				if (fire) begin
					if (frame_end_s1) begin
						phase_d = PH_CRC_HI;
					end else begin
						consume = 1'b1;
					end
				end
			end
			PH_CRC_HI: begin
				enc_in = fcs[15:8];
				if (fire) begin
					phase_d = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				enc_in       = fcs[7:0];
				crc_step.clr = fire;
				enc_step.clr = fire;
				if (fire) begin
					phase_d = PH_DATA;
					consume = 1'b1;
				end
			end
			default: begin
				phase_d = PH_DATA;
			end
		endcase
	end

	ufcre_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (crc_step),
		.data   (data_byte_s1),
		.crc    (crc)
	);

	ufcre_enc u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (enc_step),
		.mode   (mode_q),
		.data   (enc_in),
		.coded  (coded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			coded_byte_q <= coded;
			is_crc_q     <= (phase_q != PH_DATA);
			last_out_q   <= (phase_q == PH_CRC_LO);
		end
	end

	assign out_valid  = out_valid_q;
	assign coded_byte = coded_byte_q;
	assign is_crc     = is_crc_q;
	assign last_out   = last_out_q;

	`UFCRE_ASSERT_IMP(a_crc_phase_holds_item, clk, arst_n,
		phase_q != PH_DATA, valid_s1 && frame_end_s1)
	`UFCRE_ASSERT_IMP(a_last_is_crc, clk, arst_n,
		out_valid && last_out, is_crc)
	`UFCRE_ASSERT_NXT(a_frame_end_enters_crc, clk, arst_n,
		fire && phase_q == PH_DATA && frame_end_s1, phase_q == PH_CRC_HI && !in_ready)
	`UFCRE_ASSERT_NXT(a_crc_cleared, clk, arst_n,
		fire && phase_q == PH_CRC_LO, crc == 16'h0000 && phase_q == PH_DATA)

endmodule

// ----- dv/uplink_frame_crc_repeat_encoder_checker.sv -----
// ----------------------------------------------------------------------------
// uplink_frame_crc_repeat_encoder_checker
// Watches both channels of the encoder, predicts every coded byte from the
// accepted frame bytes and the current repeat mode, and compares in order.
// ----------------------------------------------------------------------------
module uplink_frame_crc_repeat_encoder_checker
	import ufcre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] coded_byte,
	input  logic       is_crc,
	input  logic       last_out,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	output int         fail_total,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] coded;
		logic       crc;
		logic       last;
	} coded_out_t;

	coded_out_t  coded_q[$];
	logic [15:0] crc_run;
	logic [15:0] shifter;
	logic [15:0] accum;
	logic [1:0]  mode_now;
	int          mismatches;

	function automatic logic [15:0] lookup_for(input logic [1:0] m);
		case (m)
			MODE_LUT_A: return LOOKUP_MODE1;
			MODE_LUT_B: return LOOKUP_MODE2;
			default:    return 16'h0000;
		endcase
	endfunction

	task automatic crc_absorb(input logic [7:0] b);
		crc_run = crc_run ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (crc_run[15]) begin
				crc_run = {crc_run[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc_run = {crc_run[14:0], 1'b0};
			end
		end
	endtask

	// Run one byte through the repeat encoder, keeping its state.
	task automatic encode_next(input logic [7:0] b, output logic [7:0] coded);
		logic [15:0] lut;
		int          pos;
		lut = lookup_for(mode_now);
		shifter = shifter | {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			// bits 9..8 of the shifter pick the slice that lands on accum bits 7..6
			pos = 2 * int'(shifter[9:8]);
			accum[7:6] = accum[7:6] ^ lut[pos + 7 -: 2];
			shifter = {shifter[14:0], 1'b0};
			accum = {accum[14:0], 1'b0};
		end
		coded = accum[15:8] ^ shifter[15:8];
	endtask

	task automatic predict_item(input logic [7:0] b, input logic e);
		logic [15:0] fcs;
		logic [7:0]  c;
		crc_absorb(b);
		encode_next(b, c);
		coded_q.push_back('{coded: c, crc: 1'b0, last: 1'b0});
		if (e) begin
			fcs = crc_run ^ CRC_INVERT;
			encode_next(fcs[15:8], c);
			coded_q.push_back('{coded: c, crc: 1'b1, last: 1'b0});
			encode_next(fcs[7:0], c);
			coded_q.push_back('{coded: c, crc: 1'b1, last: 1'b1});
			crc_run = '0;
			shifter = '0;
			accum = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		coded_out_t want;
		if (!arst_n) begin
			crc_run = '0;
			shifter = '0;
			accum = '0;
			mode_now = MODE_COPY;
			mismatches = 0;
			coded_q.delete();
			fail_total <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				mode_now = cfg_wr_data;
			end
			if (out_valid && out_ready) begin
				if (coded_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected output transfer: coded %02h crc %0b last %0b",
							coded_byte, is_crc, last_out);
					end
				end else begin
					want = coded_q.pop_front();
					if (want.coded !== coded_byte || want.crc !== is_crc ||
							want.last !== last_out) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected coded %02h crc %0b last %0b, got coded %02h crc %0b last %0b",
								want.coded, want.crc, want.last, coded_byte, is_crc, last_out);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_item(data_byte, frame_end);
			end
			fail_total <= mismatches;
			outstanding <= coded_q.size();
		end
	end

endmodule

// ----- dv/uplink_frame_crc_repeat_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// uplink_frame_crc_repeat_encoder_tb
// Drives frames of bytes through the encoder under every repeat mode, with
// random gaps and stalls, a long output hold-off and mode changes inside an
// open frame; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module uplink_frame_crc_repeat_encoder_tb
	import ufcre_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam int         HOLD_CYCLES = 60;
	localparam int         RUN_ITEMS   = 245;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       frame_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] coded_byte;
	logic       is_crc;
	logic       last_out;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;
	int         fail_total;
	int         outstanding;

	bit calm;
	bit hold_off_req;
	int items_sent;

	uplink_frame_crc_repeat_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coded_byte (coded_byte),
		.is_crc     (is_crc),
		.last_out   (last_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	uplink_frame_crc_repeat_encoder_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coded_byte (coded_byte),
		.is_crc     (is_crc),
		.last_out   (last_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_total (fail_total),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#200000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req <= 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 11);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic e);
		int gap;
		gap = (!calm && $urandom_range(99) < 5) ? int'($urandom_range(1, 4)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		frame_end <= e;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Send n random bytes; close the frame on the last one if asked.
	task automatic send_bytes(input int n, input bit close);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(7) == 0) begin
				b = $urandom_range(1) ? 8'hff : 8'h00;
			end else begin
				b = 8'($urandom_range(255));
			end
			send_byte(b, close && (i == n - 1));
		end
	endtask

	// Hold the input until every predicted byte has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input logic [1:0] m);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		bit calm_done;
		bit hold_done;
		int len;
		int cut;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		frame_end = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = MODE_COPY;
		calm = 1'b0;
		hold_off_req = 1'b0;
		items_sent = 0;
		calm_done = 1'b0;
		hold_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain copy after reset, field extremes
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
		set_mode(MODE_LUT_A);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'haa, 1'b1);
		set_mode(MODE_LUT_B);
		send_byte(8'h55, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		// frame of a single byte
		send_byte(8'h00, 1'b1);
		// unused mode value acts as a copy
		set_mode(MODE_SPARE);
		send_byte(8'h0f, 1'b0);
		send_byte(8'hf0, 1'b1);
		// mode changes inside an open frame keep the encoder state
		set_mode(MODE_LUT_A);
		send_byte(8'h3c, 1'b0);
		send_byte(8'hc3, 1'b0);
		set_mode(MODE_LUT_B);
		send_byte(8'h96, 1'b0);
		set_mode(MODE_COPY);
		send_byte(8'h7e, 1'b1);

		while (items_sent < RUN_ITEMS) begin
			if (!calm_done && items_sent > 100) begin
				calm_done = 1'b1;
				calm <= 1'b1;
				send_bytes(20, 1'b1);
				send_bytes(20, 1'b1);
				calm <= 1'b0;
			end else if (!hold_done && items_sent > 180) begin
				// keep offering while the output is held so the block backs up
				hold_done = 1'b1;
				calm <= 1'b1;
				hold_off_req <= 1'b1;
				send_bytes(16, 1'b1);
				calm <= 1'b0;
			end else begin
				pick = $urandom_range(9);
				if (pick == 0) begin
					set_mode(2'($urandom_range(3)));
				end
				len = ($urandom_range(9) == 0) ? int'($urandom_range(12, 24))
					: int'($urandom_range(1, 8));
				if (pick == 1 && len > 1) begin
					cut = $urandom_range(1, len - 1);
					send_bytes(cut, 1'b0);
					set_mode(2'($urandom_range(3)));
					send_bytes(len - cut, 1'b1);
				end else begin
					send_bytes(len, 1'b1);
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
		if (fail_total == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ufcre_pkg.sv
hw/rtl/ufcre_crc.sv
hw/rtl/ufcre_enc.sv
hw/rtl/uplink_frame_crc_repeat_encoder.sv
dv/uplink_frame_crc_repeat_encoder_checker.sv
dv/uplink_frame_crc_repeat_encoder_tb.sv
